/* rtl/tccw_pkg.sv */
// Shared types and constants for the text console cell writer.
// Holds screen geometry, operation codes and the controller/datapath command
// and status structures. No dependencies.
package tccw_pkg;

   // Screen geometry and derived widths.
   localparam int Cols   = 80;
   localparam int Rows   = 25;
   localparam int Cells  = Cols * Rows;
   localparam int ColW   = $clog2(Cols);
   localparam int RowW   = $clog2(Rows);
   localparam int AddrW  = $clog2(Cells);
   localparam int SweepW = $clog2(Cells + 1);

   // Fixed field widths of the request and response items.
   localparam int OpW     = 2;
   localparam int CharW   = 8;
   localparam int CoordW  = 16;
   localparam int IdxW    = 11;
   localparam int ColorW  = 4;
   localparam int CellW   = 16;
   localparam int RegXW   = 7;
   localparam int RegYW   = 5;
   localparam int RegWW   = 7;
   localparam int RegHW   = 5;
   localparam int CsrIdxW = 2;
   localparam int CsrDatW = 4;

   // Character and cell constants.
   localparam logic [CharW-1:0] NewlineChar = 8'h0a;
   localparam logic [CharW-1:0] SpaceChar   = 8'h20;
   localparam logic [CellW-1:0] InitCell    = 16'h0f00;
   localparam logic [ColorW-1:0] FgReset    = 4'hf;
   localparam logic [ColorW-1:0] BgReset    = 4'h0;

   // Request operation codes.
   typedef enum logic [OpW-1:0] {
      OP_WRITE = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // Configuration register indexes.
   typedef enum logic [CsrIdxW-1:0] {
      CSR_FG     = 2'd0,
      CSR_BG     = 2'd1,
      CSR_BYPASS = 2'd2
   } csr_type;

   // Word written by a store sweep.
   typedef enum logic [1:0] {
      FILL_INIT,
      FILL_COLOR,
      FILL_SPACE
   } fill_type;

   // Kind of response loaded into the output register.
   typedef enum logic [1:0] {
      RPT_CHAR,
      RPT_FULL,
      RPT_READ
   } rpt_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     capture;
      logic     sweep_start;
      fill_type fill;
      logic     sweep_run;
      logic     cur_set;
      logic     cur_home;
      logic     cur_newline;
      logic     cur_advance;
      logic     cur_bottom;
      logic     char_write;
      logic     read_issue;
      logic     out_load;
      rpt_type  out_sel;
      logic     out_last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   is_newline;
      logic   bypass;
      logic   last_row;
      logic   wrap;
      logic   sweep_done;
      logic   slot_free;
   } sts_type;

endpackage

/* rtl/tccw_ctrl.sv */
// Controller state machine of the text console cell writer.
// Sequences requests into datapath commands; depends on tccw_pkg.
module tccw_ctrl import tccw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_CHAR,
      S_SCROLL,
      S_CLEAR,
      S_FULL,
      S_READ
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.fill  = FILL_INIT;
      cmd.out_sel = RPT_CHAR;
      req_ready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.sweep_run = 1'b1;
            if (sts.sweep_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.op)
               OP_WRITE: begin
                  if (sts.bypass) begin
                     state_in = S_IDLE;
                  end else if (sts.is_newline) begin
                     cmd.cur_newline = 1'b1;
                     if (sts.last_row) begin
                        cmd.sweep_start = 1'b1;
                        cmd.fill        = FILL_SPACE;
                        state_in        = S_SCROLL;
                     end else begin
                        state_in = S_IDLE;
                     end
                  end else begin
                     state_in = S_CHAR;
                  end
               end
               OP_SET: begin
                  cmd.cur_set = 1'b1;
                  state_in    = S_IDLE;
               end
               OP_CLEAR: begin
                  if (sts.bypass) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.sweep_start = 1'b1;
                     cmd.fill        = FILL_COLOR;
                     cmd.cur_home    = 1'b1;
                     state_in        = S_CLEAR;
                  end
               end
               OP_READ: begin
                  cmd.read_issue = 1'b1;
                  state_in       = S_READ;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_CHAR: begin
            if (sts.slot_free) begin
               cmd.char_write  = 1'b1;
               cmd.cur_advance = 1'b1;
               cmd.out_load    = 1'b1;
               cmd.out_sel     = RPT_CHAR;
               cmd.out_last    = !sts.wrap;
               if (sts.wrap) begin
                  cmd.sweep_start = 1'b1;
                  cmd.fill        = FILL_SPACE;
                  state_in        = S_SCROLL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SCROLL: begin
            cmd.sweep_run = 1'b1;
            if (sts.sweep_done) begin
               cmd.cur_bottom = 1'b1;
               state_in       = S_FULL;
            end
         end
         S_CLEAR: begin
            cmd.sweep_run = 1'b1;
            if (sts.sweep_done) state_in = S_FULL;
         end
         S_FULL: begin
            if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = RPT_FULL;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_READ: begin
            if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = RPT_READ;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // A response is only loaded when the output register can take it.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.slot_free)
      else $error("response loaded into an occupied output register");

   // A sweep is only started from the decode or character stage.
   a_sweep_start_src: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_start |-> (state_ff == S_DECODE || state_ff == S_CHAR))
      else $error("sweep started from an unexpected state");

endmodule

/* rtl/tccw_datapath.sv */
// Datapath of the text console cell writer: cell store, cursor, colour
// registers, store sweep engine and response register. Depends on tccw_pkg.
module tccw_datapath import tccw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [OpW-1:0]     req_op,
   input  logic [CharW-1:0]   req_char,
   input  logic [CoordW-1:0]  req_x,
   input  logic [CoordW-1:0]  req_y,
   input  logic [IdxW-1:0]    req_idx,
   input  logic               csr_wr_en,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CsrDatW-1:0] csr_wdata,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic [RegXW-1:0]   rsp_x,
   output logic [RegYW-1:0]   rsp_y,
   output logic [RegWW-1:0]   rsp_w,
   output logic [RegHW-1:0]   rsp_h,
   output logic [CellW-1:0]   rsp_cell,
   output logic               rsp_last
);

   // Cell store.
   logic [CellW-1:0] mem [Cells];

   // Captured request fields.
   op_type            op_ff;
   logic [CharW-1:0]  char_ff;
   logic [CoordW-1:0] x_ff, y_ff;
   logic [IdxW-1:0]   idx_ff;

   // Configuration registers.
   logic [ColorW-1:0] fg_ff, bg_ff;
   logic              bypass_ff;

   // Cursor.
   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;
   logic [AddrW-1:0] cur_addr;

   // Sweep engine.
   logic [SweepW-1:0] sweep_ff;
   fill_type          mode_ff;
   logic              pend_ff, copy_ff;
   logic [AddrW-1:0]  wr_addr_ff;
   logic              issue, issue_copy;

   // Memory ports.
   logic [CellW-1:0] rd_q;
   logic [AddrW-1:0] rd_addr;
   logic             rd_en;
   logic [AddrW-1:0] wr_addr;
   logic [CellW-1:0] wr_data, fill_word, color_word;
   logic             wr_en;

   // Response register.
   logic             valid_ff;
   logic             idx_ok;

   assign color_word = {bg_ff, fg_ff, CharW'(0)};
   assign cur_addr   = AddrW'(int'(row_ff) * Cols + int'(col_ff));
   assign idx_ok     = (int'(idx_ff) < Cells);

   // Capture the request fields on acceptance.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_op);
         char_ff <= req_char;
         x_ff    <= req_x;
         y_ff    <= req_y;
         idx_ff  <= req_idx;
      end
   end

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff     <= FgReset;
         bg_ff     <= BgReset;
         bypass_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FG:     fg_ff     <= csr_wdata;
            CSR_BG:     bg_ff     <= csr_wdata;
            CSR_BYPASS: bypass_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Cursor update. The row never steps past the bottom; a scroll follows.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.cur_set) begin
         if (x_ff[CoordW-1]) col_in = '0;
         else if (x_ff >= CoordW'(Cols)) col_in = ColW'(Cols - 1);
         else col_in = x_ff[ColW-1:0];
         if (y_ff[CoordW-1]) row_in = '0;
         else if (y_ff >= CoordW'(Rows)) row_in = RowW'(Rows - 1);
         else row_in = y_ff[RowW-1:0];
      end else if (cmd.cur_home) begin
         col_in = '0;
         row_in = '0;
      end else if (cmd.cur_bottom) begin
         col_in = '0;
         row_in = RowW'(Rows - 1);
      end else if (cmd.cur_newline) begin
         col_in = '0;
         if (!sts.last_row) row_in = row_ff + 1'b1;
      end else if (cmd.cur_advance) begin
         if (col_ff == ColW'(Cols - 1)) begin
            col_in = '0;
            if (!sts.last_row) row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Sweep issue: one destination cell a cycle. A scroll copies the cell one
   // row below; the bottom row and the other sweeps write the fill word.
   assign issue      = cmd.sweep_run && (sweep_ff < SweepW'(Cells));
   assign issue_copy = issue && (mode_ff == FILL_SPACE)
                       && (sweep_ff < SweepW'(Cells - Cols));

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         mode_ff  <= FILL_INIT;
         pend_ff  <= 1'b0;
      end else if (cmd.sweep_start) begin
         sweep_ff <= '0;
         mode_ff  <= cmd.fill;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= issue;
         if (issue) sweep_ff <= sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= AddrW'(sweep_ff);
      copy_ff    <= issue_copy;
   end

   // Fill word of the running sweep.
   always_comb begin
      case (mode_ff)
         FILL_COLOR: fill_word = color_word;
         FILL_SPACE: fill_word = color_word | CellW'(SpaceChar);
         default:    fill_word = InitCell;
      endcase
   end

   // Memory port selection.
   always_comb begin
      if (issue_copy) begin
         rd_addr = AddrW'(sweep_ff + SweepW'(Cols));
         rd_en   = 1'b1;
      end else begin
         rd_addr = AddrW'(idx_ff);
         rd_en   = cmd.read_issue && idx_ok;
      end
      if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = wr_addr_ff;
         wr_data = copy_ff ? rd_q : fill_word;
      end else begin
         wr_en   = cmd.char_write;
         wr_addr = cur_addr;
         wr_data = color_word | CellW'(char_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_q <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_last <= cmd.out_last;
         case (cmd.out_sel)
            RPT_CHAR: begin
               rsp_kind <= 1'b0;
               rsp_x    <= RegXW'(col_ff);
               rsp_y    <= RegYW'(row_ff);
               rsp_w    <= RegWW'(1);
               rsp_h    <= RegHW'(1);
               rsp_cell <= '0;
            end
            RPT_FULL: begin
               rsp_kind <= 1'b0;
               rsp_x    <= '0;
               rsp_y    <= '0;
               rsp_w    <= RegWW'(Cols);
               rsp_h    <= RegHW'(Rows);
               rsp_cell <= '0;
            end
            default: begin
               rsp_kind <= 1'b1;
               rsp_x    <= '0;
               rsp_y    <= '0;
               rsp_w    <= '0;
               rsp_h    <= '0;
               rsp_cell <= idx_ok ? rd_q : '0;
            end
         endcase
      end
   end

   assign rsp_valid = valid_ff;

   // Status to the controller.
   assign sts.op         = op_ff;
   assign sts.is_newline = (char_ff == NewlineChar);
   assign sts.bypass     = bypass_ff;
   assign sts.last_row   = (row_ff == RowW'(Rows - 1));
   assign sts.wrap       = sts.last_row && (col_ff == ColW'(Cols - 1));
   assign sts.sweep_done = (sweep_ff == SweepW'(Cells));
   assign sts.slot_free  = !valid_ff || rsp_ready;

   // The cursor always stays on the screen.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (int'(col_ff) < Cols) && (int'(row_ff) < Rows))
      else $error("cursor left the screen");

   // A sweep write and a character write never contend for the write port.
   a_write_port: assert property (@(posedge clock) disable iff (reset)
      !(pend_ff && cmd.char_write))
      else $error("sweep and character write collide");

   // The sweep counter never runs past the store.
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      int'(sweep_ff) <= Cells)
      else $error("sweep counter beyond the store");

   // Read data carries no region.
   a_read_region: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_kind) |-> (rsp_w == '0 && rsp_h == '0))
      else $error("read response with a region");

endmodule

/* rtl/text_console_cell_writer_core.sv */
// Top level of the text console cell writer.
// Joins the controller (tccw_ctrl) and datapath (tccw_datapath); uses tccw_pkg.
//
// The block keeps an 80 by 25 store of text cells and a cursor, and takes one
// request at a time. A set cursor is done in the decode step; a character
// write or a read also needs a further step after decode, and a read uses the
// single registered read port of the store. A character write or a read waits
// in that step while the output register still holds an unread response. A
// scroll or a clear sweeps the whole store through its one write port, one cell
// a cycle, before its full-screen report is offered. After reset a clearing
// pass fills the store while req_tready stays low; configuration writes are
// taken throughout. A finished response waits in an output register, so the
// next request is taken while it is still unread.
module text_console_cell_writer_core import tccw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [55:0]        req_tdata,  // char_code, cursor_x, cursor_y, cell_index
   input  logic [1:0]         req_tuser,  // op
   input  logic               req_tlast,  // string_end
   // Response channel.
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [39:0]        rsp_tdata,  // region_x, region_y, region_w, region_h,
                                          // read_cell
   output logic [0:0]         rsp_tuser,  // kind
   output logic               rsp_tlast,  // last
   // Configuration port.
   input  logic               csr_wr_en,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CsrDatW-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   logic              rsp_kind;
   logic [RegXW-1:0]  rsp_x;
   logic [RegYW-1:0]  rsp_y;
   logic [RegWW-1:0]  rsp_w;
   logic [RegHW-1:0]  rsp_h;
   logic [CellW-1:0]  rsp_cell;

   // Sequencing of each request.
   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Store, cursor and response register. The string end flag has no effect
   // on the cells and is not carried further.
   tccw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_op    (req_tuser),
      .req_char  (req_tdata[7:0]),
      .req_x     (req_tdata[23:8]),
      .req_y     (req_tdata[39:24]),
      .req_idx   (req_tdata[50:40]),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (rsp_kind),
      .rsp_x     (rsp_x),
      .rsp_y     (rsp_y),
      .rsp_w     (rsp_w),
      .rsp_h     (rsp_h),
      .rsp_cell  (rsp_cell),
      .rsp_last  (rsp_tlast)
   );

   // Pack the response fields, lowest first.
   assign rsp_tdata = {rsp_cell, rsp_h, rsp_w, rsp_y, rsp_x};
   assign rsp_tuser = rsp_kind;

endmodule
